### sv/assert_macros.svh
// Assertion macros for the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low.
`define ESD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check of the form "antecedent implies consequent in the same cycle".
`define ESD_ASSERT_IMP(label, ante, cons, msg) \
  `ESD_ASSERT(label, (ante) |-> (cons), msg)

// Concurrent check of the form "antecedent implies consequent in the following cycle".
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
  `ESD_ASSERT(label, (ante) |=> (cons), msg)

`endif

### sv/esd_pkg.sv
// Types, constants and helper functions of the escape sequence decoder.
package esd_pkg;

  // Width of a code point that can still be valid (up to 0x10FFFF).
  localparam int CODE_W = 21;
  // Width of one accumulation step before the range check (21 bits times 16 plus a digit).
  localparam int ACC_W  = CODE_W + 4;

  localparam logic [ACC_W-1:0] CODE_MAX = ACC_W'(24'h10FFFF);

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_U    = 8'h75;

  // Saturation point of the digit counter: only "at least one" and "at least four" matter.
  localparam logic [2:0] DIGITS_SAT  = 3'd4;
  localparam logic [2:0] DIGITS_HEX  = 3'd1;
  localparam logic [2:0] DIGITS_UNI  = 3'd4;

  typedef enum logic [2:0] {
    KIND_AWAIT,
    KIND_OCTAL,
    KIND_HEX,
    KIND_UNICODE,
    KIND_OTHER
  } kind_t;

  typedef enum logic [1:0] {
    JOB_BYTE,
    JOB_UTF8,
    JOB_ERROR
  } job_kind_t;

  // One decoded escape, handed from the front end to the output side.
  typedef struct packed {
    job_kind_t         kind;
    logic [CODE_W-1:0] value;
  } job_t;

  // Returns {known, byte} for a one-character escape body.
  function automatic logic [8:0] single_escape(logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      8'h3F:   r = {1'b1, 8'h3F};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h74:   r = {1'b1, 8'h09};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h76:   r = {1'b1, 8'h0B};
      8'h61:   r = {1'b1, 8'h07};
      8'h65:   r = {1'b1, 8'h1B};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  // Returns {is_digit, value} for a character in octal or hexadecimal.
  function automatic logic [4:0] digit_of(logic [7:0] c, logic octal);
    logic [4:0] r;
    r = 5'd0;
    if (octal) begin
      if (c >= 8'h30 && c <= 8'h37) r = {1'b1, c[3:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
    end
    return r;
  endfunction

endpackage

### sv/esd_if.sv
// Valid/ready channels of the escape sequence decoder: characters in, decoded bytes out.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_body;

  modport source (output valid, output char_in, output end_of_body, input ready);
  modport sink   (input valid, input char_in, input end_of_body, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last_byte;
  logic       error;

  modport source (output valid, output byte_out, output last_byte, output error, input ready);
  modport sink   (input valid, input byte_out, input last_byte, input error, output ready);
endinterface

### sv/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: front end, job queue and output side.
//
// The decoder takes the characters that follow a backslash, one character per beat, with
// end_of_body set on the final character, and answers each body with one to four output
// beats: the decoded bytes (a single control or quote byte, the low byte of an octal or
// hexadecimal value, or the UTF-8 encoding of a unicode value), or a single beat with
// error set and byte_out zero. Nothing appears on the output until the final character of
// a body has been taken; last_byte marks the final beat of each body. Input beats are
// accepted at one per cycle, since each character costs only one shift-and-add of the
// digit value in the front end. Output beats leave at one per cycle while out_bus.ready
// is high, so a unicode body that encodes to four bytes occupies the output side for
// four beats; the job queue of QUEUE_DEPTH entries lets the front end keep accepting
// characters meanwhile, and input ready drops only while that queue is full. The output
// register holds each beat until it is taken, so out_bus.ready reaches only the read
// side of the queue and never the input ready. There are no configuration registers.

`include "assert_macros.svh"

module escape_sequence_decoder
  import esd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  esd_in_if.sink    in_bus,
  esd_out_if.source out_bus
);

  logic                             push, pop, full, head_valid;
  job_t                             push_job, head_job;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

  // The front end classifies each body and hands over one job on its final character.
  esd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  // Jobs wait here while the output side is still busy with earlier bytes.
  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .level      (level)
  );

  // The output side turns each job into its beats.
  esd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_bus    (out_bus)
  );

  // The queue never holds more jobs than it has entries.
  `ESD_ASSERT(a_queue_level, level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue overrun")

  // An error is always a single beat carrying a zero byte.
  `ESD_ASSERT_IMP(a_error_beat, out_bus.valid && out_bus.error,
                  out_bus.last_byte && out_bus.byte_out == 8'h00, "malformed error beat")

  // Once a multi-byte sequence has started, its next byte follows without a gap.
  `ESD_ASSERT_NEXT(a_sequence_unbroken,
                   out_bus.valid && out_bus.ready && !out_bus.last_byte,
                   out_bus.valid, "gap inside a multi-byte sequence")

endmodule

### sv/esd_front.sv
// Front end: takes characters, tracks the escape kind and digit value, pushes one job per body.
module esd_front
  import esd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  esd_in_if.sink in_bus,
  input  logic   queue_full,
  output logic   push,
  output job_t   push_job
);

  logic              first_r, first_nxt;
  kind_t             kind_r, kind_nxt;
  logic              open_r, open_nxt;
  logic [2:0]        count_r, count_nxt;
  logic [CODE_W-1:0] acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;

  logic              accept;
  logic [4:0]        dig;
  logic [ACC_W-1:0]  step;
  logic [8:0]        single;

  assign in_bus.ready = !queue_full;
  assign accept       = in_bus.valid && in_bus.ready;

  assign dig  = digit_of(in_bus.char_in, kind_r == KIND_OCTAL);
  assign step = (kind_r == KIND_OCTAL) ? {1'b0, acc_r, 3'b000} | ACC_W'(dig[3:0])
                                       : {acc_r, 4'b0000} | ACC_W'(dig[3:0]);

  // Next state of the body being decoded.
  always_comb begin
    kind_nxt  = kind_r;
    open_nxt  = open_r;
    count_nxt = count_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    if (first_r) begin
      priority if (in_bus.char_in == CH_ZERO) kind_nxt = KIND_OCTAL;
      else if (in_bus.char_in == CH_X)        kind_nxt = KIND_HEX;
      else if (in_bus.char_in == CH_U)        kind_nxt = KIND_UNICODE;
      else                                    kind_nxt = KIND_OTHER;
    end else if (open_r && (kind_r == KIND_OCTAL || kind_r == KIND_HEX ||
                            kind_r == KIND_UNICODE)) begin
      if (dig[4]) begin
        if (!ovf_r) begin
          acc_nxt = step[CODE_W-1:0];
          ovf_nxt = step > CODE_MAX;
        end
        if (count_r != DIGITS_SAT) count_nxt = count_r + 3'd1;
      end else begin
        open_nxt = 1'b0;
      end
    end
    first_nxt = 1'b0;
  end

  // Job for the final character of a body.
  always_comb begin
    single         = single_escape(in_bus.char_in);
    push           = accept && in_bus.end_of_body;
    push_job.kind  = JOB_ERROR;
    push_job.value = '0;
    if (first_r) begin
      if (single[8]) begin
        push_job.kind  = JOB_BYTE;
        push_job.value = CODE_W'(single[7:0]);
      end
    end else if ((kind_nxt == KIND_OCTAL || kind_nxt == KIND_HEX) &&
                 count_nxt >= DIGITS_HEX && !ovf_nxt) begin
      push_job.kind  = JOB_BYTE;
      push_job.value = acc_nxt;
    end else if (kind_nxt == KIND_UNICODE && count_nxt >= DIGITS_UNI && !ovf_nxt) begin
      push_job.kind  = JOB_UTF8;
      push_job.value = acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_bus.end_of_body)) begin
      first_r <= 1'b1;
      kind_r  <= KIND_AWAIT;
      open_r  <= 1'b1;
      count_r <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      first_r <= first_nxt;
      kind_r  <= kind_nxt;
      open_r  <= open_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

### sv/esd_queue.sv
// Short job queue between the front end and the output side.
module esd_queue
  import esd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  job_t                       push_job,
  input  logic                       pop,
  output logic                       full,
  output logic                       head_valid,
  output job_t                       head_job,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = mem_r[rd_ptr_r];
  assign level      = count_r;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

### sv/esd_back.sv
// Output side: expands each job into one to four beats held in an output register.
module esd_back
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  esd_out_if.source  out_bus
);

  logic       out_valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       err_r;
  logic [1:0] idx_r;
  logic [1:0] nm1;
  logic       load;

  function automatic logic [7:0] utf8_byte(logic [CODE_W-1:0] v, logic [1:0] n_m1,
                                           logic [1:0] idx);
    logic [1:0]        grp;
    logic [CODE_W-1:0] sh;
    logic [7:0]        r;
    grp = n_m1 - idx;
    unique case (grp)
      2'd0:    sh = v;
      2'd1:    sh = v >> 6;
      2'd2:    sh = v >> 12;
      default: sh = v >> 18;
    endcase
    if (idx == 2'd0) begin
      unique case (n_m1)
        2'd0:    r = sh[7:0];
        2'd1:    r = 8'hC0 | sh[7:0];
        2'd2:    r = 8'hE0 | sh[7:0];
        default: r = 8'hF0 | sh[7:0];
      endcase
    end else begin
      r = {2'b10, sh[5:0]};
    end
    return r;
  endfunction

  // Number of beats in the head job, less one.
  always_comb begin
    nm1 = 2'd0;
    if (head_job.kind == JOB_UTF8) begin
      priority if (head_job.value < CODE_W'(21'h80))  nm1 = 2'd0;
      else if (head_job.value < CODE_W'(21'h800))     nm1 = 2'd1;
      else if (head_job.value < CODE_W'(21'h10000))   nm1 = 2'd2;
      else                                            nm1 = 2'd3;
    end
  end

  always_comb begin
    last_nxt = idx_r == nm1;
    unique case (head_job.kind)
      JOB_BYTE: byte_nxt = head_job.value[7:0];
      JOB_UTF8: byte_nxt = utf8_byte(head_job.value, nm1, idx_r);
      default:  byte_nxt = 8'h00;
    endcase
  end

  assign load = head_valid && (!out_valid_r || out_bus.ready);
  assign pop  = load && last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load)               out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
      if (load) idx_r <= last_nxt ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      err_r  <= head_job.kind == JOB_ERROR;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.byte_out  = byte_r;
  assign out_bus.last_byte = last_r;
  assign out_bus.error     = err_r;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench of the escape sequence decoder: directed bodies, then random ones.
module tb_top
  import esd_pkg::*;
();

  // Characters to send in all; the random part stops once this many have been taken.
  localparam int ITEMS_TARGET = 410;
  // A hard cap set well above what the slowest correct run takes, leaving ample headroom.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles to keep watching the output once nothing more is expected.
  localparam int DRAIN_CYCLES = 20;
  // Only the first few mismatches are printed; the rest are still counted.
  localparam int REPORT_MAX   = 30;

  // One output beat as the bench expects to see it.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       error;
  } dec_byte_t;

  // One row of the directed table: up to eight characters, the first one in the
  // highest used byte, and optionally the single beat that the body must give.
  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  len;
    logic        fixed;
    dec_byte_t   want;
  } dir_row_t;

  localparam int DIR_ROWS = 8;

  logic clk;
  logic rst_n;

  esd_in_if  in_ch ();
  esd_out_if out_ch ();

  escape_sequence_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  // Decoder state as the bench tracks it, updated on every accepted character.
  kind_t       esc_kind;
  logic [3:0]  esc_pos;
  logic        esc_run_open;
  logic [3:0]  esc_digits;
  logic [31:0] esc_value;
  logic        esc_too_big;

  // Output beats that have been predicted but not yet seen, oldest first.
  dec_byte_t   pending_bytes[$];
  // Characters of the body that is about to be sent.
  logic [7:0]  body[$];
  dir_row_t    dir_rows[DIR_ROWS];

  int unsigned n_errors  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned chars_sent = 0;
  // While set, neither side idles nor stalls.
  bit          quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A hard stop in case the decoder hangs or loses a beat for good.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report(input string what);
    n_errors++;
    if (n_errors <= REPORT_MAX) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void clear_escape();
    esc_kind     = KIND_AWAIT;
    esc_pos      = 4'd0;
    esc_run_open = 1'b1;
    esc_digits   = 4'd0;
    esc_value    = 32'd0;
    esc_too_big  = 1'b0;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic l, input logic e);
    dec_byte_t item;
    item = '{value: b, last: l, error: e};
    pending_bytes.push_back(item);
  endfunction

  // Works out what one accepted character does to the decoder. On the final
  // character of a body the expected beats are queued and the state cleared.
  // A fixed expectation, where given, takes the place of the computed one.
  function automatic void decode_char(input logic [7:0] c, input logic eob,
                                      input logic fixed, input dec_byte_t want);
    logic        first;
    logic        is_dig;
    logic [3:0]  dig;
    logic [31:0] v;
    first = (esc_pos == 4'd0);
    if (first) begin
      if (c == CH_ZERO) esc_kind = KIND_OCTAL;
      else if (c == CH_X) esc_kind = KIND_HEX;
      else if (c == CH_U) esc_kind = KIND_UNICODE;
      else esc_kind = KIND_OTHER;
    end else if (esc_run_open && (esc_kind == KIND_OCTAL || esc_kind == KIND_HEX ||
                                  esc_kind == KIND_UNICODE)) begin
      is_dig = 1'b1;
      dig    = 4'd0;
      if (esc_kind == KIND_OCTAL) begin
        if (c >= "0" && c <= "7") dig = c[3:0];
        else is_dig = 1'b0;
      end else if (c >= "0" && c <= "9") begin
        dig = c[3:0];
      end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
        // Both letter ranges start at an odd code, so the low three bits plus nine give the digit.
        dig = 4'(c[2:0] + 4'd9);
      end else begin
        is_dig = 1'b0;
      end
      if (is_dig) begin
        // Once the value is out of range it is frozen; only the digit count still moves.
        if (!esc_too_big) begin
          esc_value = esc_value * ((esc_kind == KIND_OCTAL) ? 32'd8 : 32'd16) + 32'(dig);
          if (esc_value > 32'h10FFFF) esc_too_big = 1'b1;
        end
        if (esc_digits != 4'd15) esc_digits++;
      end else begin
        // The first non-digit closes the run; whatever follows is ignored.
        esc_run_open = 1'b0;
      end
    end
    if (esc_pos != 4'd15) esc_pos++;
    if (!eob) return;

    v = esc_value;
    if (fixed) begin
      pending_bytes.push_back(want);
    end else if (first) begin
      case (c)
        8'h22, 8'h27, 8'h3F, 8'h5C: push_byte(c, 1'b1, 1'b0);
        "t":     push_byte(8'h09, 1'b1, 1'b0);
        "n":     push_byte(8'h0A, 1'b1, 1'b0);
        "r":     push_byte(8'h0D, 1'b1, 1'b0);
        "b":     push_byte(8'h08, 1'b1, 1'b0);
        "f":     push_byte(8'h0C, 1'b1, 1'b0);
        "v":     push_byte(8'h0B, 1'b1, 1'b0);
        "a":     push_byte(8'h07, 1'b1, 1'b0);
        "e":     push_byte(8'h1B, 1'b1, 1'b0);
        default: push_byte(8'h00, 1'b1, 1'b1);
      endcase
    end else if ((esc_kind == KIND_OCTAL || esc_kind == KIND_HEX) && esc_digits >= 4'd1 &&
                 !esc_too_big) begin
      push_byte(v[7:0], 1'b1, 1'b0);
    end else if (esc_kind == KIND_UNICODE && esc_digits >= 4'd4 && !esc_too_big) begin
      // UTF-8: one to four beats depending on the size of the code point.
      if (v < 32'h80) begin
        push_byte(v[7:0], 1'b1, 1'b0);
      end else if (v < 32'h800) begin
        push_byte(8'hC0 | 8'(v >> 6), 1'b0, 1'b0);
        push_byte(8'h80 | 8'(v & 32'h3F), 1'b1, 1'b0);
      end else if (v < 32'h10000) begin
        push_byte(8'hE0 | 8'(v >> 12), 1'b0, 1'b0);
        push_byte(8'h80 | 8'((v >> 6) & 32'h3F), 1'b0, 1'b0);
        push_byte(8'h80 | 8'(v & 32'h3F), 1'b1, 1'b0);
      end else begin
        push_byte(8'hF0 | 8'(v >> 18), 1'b0, 1'b0);
        push_byte(8'h80 | 8'((v >> 12) & 32'h3F), 1'b0, 1'b0);
        push_byte(8'h80 | 8'((v >> 6) & 32'h3F), 1'b0, 1'b0);
        push_byte(8'h80 | 8'(v & 32'h3F), 1'b1, 1'b0);
      end
    end else begin
      push_byte(8'h00, 1'b1, 1'b1);
    end
    clear_escape();
  endfunction

  // Idle cycles before the next beat: mostly none, often a few, now and then many.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A hexadecimal digit character, upper or lower case at random.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    if ($urandom_range(0, 1) == 0) return 8'h41 + 8'(n) - 8'd10;
    return 8'h61 + 8'(n) - 8'd10;
  endfunction

  // Appends ndig digits of v, most significant first; digits beyond v come out as zeros.
  function automatic void add_digits(input logic [31:0] v, input int ndig, input logic octal);
    for (int i = ndig - 1; i >= 0; i--) begin
      if (octal) body.push_back(8'h30 + 8'((i < 10) ? v[3*i +: 3] : 3'd0));
      else body.push_back(hex_char((i < 8) ? v[4*i +: 4] : 4'd0));
    end
  endfunction

  // Builds one random escape body. Most are well formed with random digits; the
  // rest are single characters, noise and bodies broken after a good first character.
  function automatic void build_body();
    int          sel;
    int          ndig;
    int          nd;
    int          n;
    logic [31:0] v;
    logic [7:0]  known[12];
    logic [7:0]  lead[3];
    known = '{8'h22, 8'h27, 8'h3F, 8'h5C, "t", "n", "r", "b", "f", "v", "a", "e"};
    lead  = '{CH_ZERO, CH_X, CH_U};
    body.delete();
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        if ($urandom_range(0, 1) == 0) body.push_back(known[$urandom_range(0, 11)]);
        else body.push_back(8'($urandom));
      end
      1, 2: begin
        body.push_back(CH_ZERO);
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        add_digits($urandom, ndig, 1'b1);
      end
      3, 4: begin
        body.push_back(CH_X);
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        add_digits($urandom, ndig, 1'b0);
      end
      5, 6, 7: begin
        body.push_back(CH_U);
        case ($urandom_range(0, 5))
          0:       v = $urandom_range(0, 32'h7F);
          1:       v = $urandom_range(32'h80, 32'h7FF);
          2:       v = $urandom_range(32'h800, 32'hFFFF);
          3:       v = $urandom_range(32'h10000, 32'h10FFFF);
          4:       v = ($urandom_range(0, 1) == 0) ? 32'h10FFFF : 32'h110000;
          default: v = $urandom_range(32'h110000, 32'hFFFFFFF);
        endcase
        nd = 1;
        while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
        ndig = (nd < 4) ? 4 : nd;
        // Long runs of leading zeros push the digit counter to saturation.
        if ($urandom_range(0, 3) == 0) ndig += $urandom_range(1, 10);
        if ($urandom_range(0, 7) == 0) ndig = $urandom_range(1, 3);
        add_digits(v, ndig, 1'b0);
      end
      8: begin
        n = $urandom_range(1, 6);
        repeat (n) body.push_back(8'($urandom));
      end
      default: begin
        body.push_back(lead[$urandom_range(0, 2)]);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 4);
        repeat (n) body.push_back(8'($urandom));
      end
    endcase
    // Trailing characters after the digits, which the decoder must ignore.
    if (sel >= 1 && sel <= 7 && $urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) body.push_back(8'($urandom));
    end
  endfunction

  // Offers one character and waits for the beat to be taken. It is entered and
  // left at a falling edge; valid is left high so that a following beat can be
  // driven straight on without a bubble.
  task automatic send_char(input logic [7:0] c, input logic eob,
                           input logic fixed, input dec_byte_t want);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_in     <= c;
    in_ch.end_of_body <= eob;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_char(c, eob, fixed, want);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_body(input logic fixed, input dec_byte_t want);
    for (int i = 0; i < body.size(); i++)
      send_char(body[i], (i == body.size() - 1), fixed, want);
  endtask

  // Holds the input idle until every predicted beat has come out.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
  endtask

  // Result side: ready is driven at the falling edge in runs of random length,
  // mostly high with short stalls and the odd long one.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:59]: begin
            out_ch.ready <= 1'b1;
            hold = $urandom_range(0, 8);
          end
          [60:91]: begin
            out_ch.ready <= 1'b0;
            hold = $urandom_range(0, 2);
          end
          default: begin
            out_ch.ready <= 1'b0;
            hold = $urandom_range(8, 30);
          end
        endcase
      end
    end
  end

  // Every output beat that is taken is matched against the oldest prediction.
  always @(posedge clk) begin
    dec_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report($sformatf("beat with byte %02h arrived with nothing expected", out_ch.byte_out));
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.byte_out !== want.value)
          report($sformatf("byte_out %02h, expected %02h", out_ch.byte_out, want.value));
        if (out_ch.last_byte !== want.last)
          report($sformatf("last_byte %b, expected %b", out_ch.last_byte, want.last));
        if (out_ch.error !== want.error)
          report($sformatf("error %b, expected %b", out_ch.error, want.error));
      end
    end
  end

  initial begin
    int nbody;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_in     = 8'h00;
    in_ch.end_of_body = 1'b0;
    clear_escape();

    // Directed bodies. The fixed beats are those that can be read off directly:
    // control characters, the value extremes and the error cases.
    dir_rows[0] = '{chars: "n", len: 4'd1, fixed: 1'b1, want: '{8'h0A, 1'b1, 1'b0}};
    // A lone character of all ones is not a known escape.
    dir_rows[1] = '{chars: 64'hFF, len: 4'd1, fixed: 1'b1, want: '{8'h00, 1'b1, 1'b1}};
    dir_rows[2] = '{chars: "x7F", len: 4'd3, fixed: 1'b1, want: '{8'h7F, 1'b1, 1'b0}};
    dir_rows[3] = '{chars: "0377", len: 4'd4, fixed: 1'b1, want: '{8'hFF, 1'b1, 1'b0}};
    // The smallest code point that needs four UTF-8 bytes.
    dir_rows[4] = '{chars: "u10000", len: 4'd6, fixed: 1'b0, want: '{8'h00, 1'b0, 1'b0}};
    // One above the largest code point, so the value is too large.
    dir_rows[5] = '{chars: "x110000", len: 4'd7, fixed: 1'b1, want: '{8'h00, 1'b1, 1'b1}};
    // Unknown first character in a longer body, with the byte extremes.
    dir_rows[6] = '{chars: 64'h00FF, len: 4'd2, fixed: 1'b1, want: '{8'h00, 1'b1, 1'b1}};
    // Too few digits for a unicode escape, followed by a trailing letter.
    dir_rows[7] = '{chars: "u12z", len: 4'd4, fixed: 1'b1, want: '{8'h00, 1'b1, 1'b1}};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      body.delete();
      for (int k = 0; k < dir_rows[r].len; k++)
        body.push_back(dir_rows[r].chars[8 * (dir_rows[r].len - 1 - k) +: 8]);
      send_body(dir_rows[r].fixed, dir_rows[r].want);
    end
    wait_for_results();

    // Random bodies. Part way through the sender pauses until the output is
    // empty, and for a stretch afterwards neither side idles.
    nbody = 0;
    while (chars_sent < ITEMS_TARGET) begin
      if (nbody == 25) wait_for_results();
      quiet = (nbody >= 40 && nbody < 55);
      build_body();
      send_body(1'b0, '{8'h00, 1'b0, 1'b0});
      nbody++;
    end
    quiet = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
